### design/pf2d_pkg.sv
// Package for the two-objective nondominated set block.
// Holds the entry record, operation and status codes, and the area unit request.
// No dependencies.
package pf2d_pkg;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] y;
    logic [15:0] pred;
    logic [15:0] tag;
  } entry_t;

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_APPEND    = 2'd1;
  localparam logic [1:0] OP_AREA      = 2'd2;
  localparam logic [1:0] OP_READ_LAST = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DOMINATED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic               clear;
    logic               valid;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } area_req_t;

endpackage

### design/pf2d_mem.sv
// One bank of entry storage: one write port, one registered read port.
// Depends on pf2d_pkg for entry_t.
module pf2d_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pf2d_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output pf2d_pkg::entry_t rdata
);
  import pf2d_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pf2d_area.sv
// Staircase area accumulator: registered 32x32 signed product, then a
// saturating 64-bit add. Depends on pf2d_pkg for area_req_t.
module pf2d_area (
  input  logic                clk,
  input  pf2d_pkg::area_req_t req,
  output logic signed [63:0]  acc
);
  import pf2d_pkg::*;

  logic signed [63:0] prod;
  logic               prod_valid;
  logic signed [64:0] sum;
  logic signed [63:0] sat;

  assign sum = {acc[63], acc} + {prod[63], prod};

  always_comb begin
    if (sum[64] != sum[63]) begin
      sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    prod       <= req.a * req.b;
    prod_valid <= req.valid;
    if (req.clear) begin
      acc <= 64'sd0;
    end else if (prod_valid) begin
      acc <= sat;
    end
  end

endmodule

### design/pareto_front_2d_insert_top.sv
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  opcode, x, y, pred, tag, borders
// result    out        done, one cycle       accepted, status, count, area, last_*
//
// Insert: two passes over the set (scan, then copy into the other bank); a
// dominated or full insert stops after the scan. Area makes one pass over the
// set. Each entry takes a read state, then an evaluate state, because the
// memory read is registered. Reset (rst, synchronous) empties the set. The
// receiver cannot stall: done marks each transaction for one cycle.
// Depends on pf2d_pkg, pf2d_mem, pf2d_area.
module pareto_front_2d_insert_top #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [30:0] x,
  input  logic [30:0] y,
  input  logic [15:0] pred,
  input  logic [15:0] tag,
  input  logic [30:0] left_x,
  input  logic [30:0] bottom_y,
  input  logic [30:0] top_y,
  input  logic [30:0] right_x,
  output logic        done,
  output logic        accepted,
  output logic [1:0]  status,
  output logic [6:0]  count,
  output logic signed [63:0] area,
  output logic [30:0] last_x,
  output logic [30:0] last_y,
  output logic [15:0] last_pred,
  output logic [15:0] last_tag
);
  import pf2d_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P1_RD  = 4'd1;
  localparam logic [3:0] S_P1_EV  = 4'd2;
  localparam logic [3:0] S_P1_END = 4'd3;
  localparam logic [3:0] S_P2_RD  = 4'd4;
  localparam logic [3:0] S_P2_EV  = 4'd5;
  localparam logic [3:0] S_P2_EV2 = 4'd6;
  localparam logic [3:0] S_P2_END = 4'd7;
  localparam logic [3:0] S_AR_RD  = 4'd8;
  localparam logic [3:0] S_AR_EV  = 4'd9;
  localparam logic [3:0] S_AR_FIN = 4'd10;
  localparam logic [3:0] S_AR_W1  = 4'd11;
  localparam logic [3:0] S_AR_W2  = 4'd12;
  localparam logic [3:0] S_RL_RD  = 4'd13;
  localparam logic [3:0] S_RL_EV  = 4'd14;

  logic [3:0]    state;
  logic          bank;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] widx;
  logic          dom;
  logic          rem_any;
  logic          placed;
  entry_t        pt;
  logic [30:0]   lx_q, by_q, ty_q, rx_q;
  logic [30:0]   px, py;

  entry_t        rd0, rd1, cur;
  logic          wr_en;
  logic          wr_bank;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  area_req_t     areq;
  logic signed [63:0] acc;

  logic          last_idx;
  logic          e_dom, e_rem;
  logic          done_next;

  assign busy     = (state != S_IDLE);
  assign cur      = bank ? rd1 : rd0;
  assign last_idx = (idx + CW'(1) == cnt);
  assign e_dom    = (cur.x <= pt.x) && (cur.y <= pt.y);
  assign e_rem    = (cur.x >= pt.x) && (cur.y >= pt.y);

  pf2d_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem0 (
    .clk(clk), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(idx[AW-1:0]), .rdata(rd0)
  );

  pf2d_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem1 (
    .clk(clk), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(idx[AW-1:0]), .rdata(rd1)
  );

  pf2d_area u_area (.clk(clk), .req(areq), .acc(acc));

  // write port: append goes to the live bank, the insert copy to the other
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = ~bank;
    wr_addr = widx[AW-1:0];
    wr_data = pt;
    case (state)
      S_IDLE: begin
        if (start && opcode == OP_APPEND && cnt < CW'(CAPACITY)) begin
          wr_en   = 1'b1;
          wr_bank = bank;
          wr_addr = cnt[AW-1:0];
          wr_data = '{x: x, y: y, pred: pred, tag: tag};
        end
      end
      S_P2_EV: begin
        if (!e_rem) begin
          wr_en = 1'b1;
          if (placed || cur.x <= pt.x) begin
            wr_data = cur;
          end
        end
      end
      S_P2_EV2: begin
        wr_en   = 1'b1;
        wr_data = cur;
      end
      S_P2_END: begin
        wr_en = !placed;
      end
      default: ;
    endcase
  end

  always_comb begin
    areq.clear = (state == S_IDLE);
    areq.valid = 1'b0;
    areq.a     = 32'sd0;
    areq.b     = 32'sd0;
    case (state)
      S_AR_EV: begin
        areq.valid = 1'b1;
        if (idx == '0) begin
          areq.a = $signed({1'b0, cur.x}) - $signed({1'b0, lx_q});
          areq.b = $signed({1'b0, ty_q}) - $signed({1'b0, by_q});
        end else begin
          areq.a = $signed({1'b0, cur.x}) - $signed({1'b0, px});
          areq.b = $signed({1'b0, py}) - $signed({1'b0, by_q});
        end
      end
      S_AR_FIN: begin
        areq.valid = 1'b1;
        areq.a     = $signed({1'b0, rx_q}) - $signed({1'b0, px});
        areq.b     = $signed({1'b0, py}) - $signed({1'b0, by_q});
      end
      default: ;
    endcase
  end

  // raise the result strobe in the cycle after a transaction finishes
  always_comb begin
    done_next = 1'b0;
    case (state)
      S_IDLE: begin
        done_next = start && (opcode == OP_APPEND ||
                              (opcode != OP_INSERT && cnt == '0));
      end
      S_P1_END: begin
        done_next = dom || (!rem_any && cnt >= CW'(CAPACITY));
      end
      S_P2_END, S_AR_W2, S_RL_EV: begin
        done_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank  <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            pt        <= '{x: x, y: y, pred: pred, tag: tag};
            lx_q      <= left_x;
            by_q      <= bottom_y;
            ty_q      <= top_y;
            rx_q      <= right_x;
            widx      <= '0;
            dom       <= 1'b0;
            rem_any   <= 1'b0;
            placed    <= 1'b0;
            area      <= 64'sd0;
            last_x    <= '0;
            last_y    <= '0;
            last_pred <= '0;
            last_tag  <= '0;
            case (opcode)
              OP_INSERT: begin
                idx      <= '0;
                accepted <= 1'b0;
                state    <= (cnt == '0) ? S_P1_END : S_P1_RD;
              end
              OP_APPEND: begin
                if (cnt < CW'(CAPACITY)) begin
                  cnt      <= cnt + CW'(1);
                  count    <= 7'(cnt + CW'(1));
                  accepted <= 1'b1;
                  status   <= ST_OK;
                end else begin
                  count    <= 7'(cnt);
                  accepted <= 1'b0;
                  status   <= ST_FULL;
                end
              end
              default: begin
                accepted <= 1'b0;
                if (cnt == '0) begin
                  count  <= 7'(cnt);
                  status <= ST_EMPTY;
                end else if (opcode == OP_AREA) begin
                  idx   <= '0;
                  state <= S_AR_RD;
                end else begin
                  idx   <= cnt - CW'(1);
                  state <= S_RL_RD;
                end
              end
            endcase
          end
        end
        // pass one: dominance test and removal flag over the live bank
        S_P1_RD: state <= S_P1_EV;
        S_P1_EV: begin
          dom     <= dom | e_dom;
          rem_any <= rem_any | e_rem;
          if (last_idx) begin
            state <= S_P1_END;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_P1_RD;
          end
        end
        S_P1_END: begin
          idx <= '0;
          if (dom || (!rem_any && cnt >= CW'(CAPACITY))) begin
            count  <= 7'(cnt);
            status <= dom ? ST_DOMINATED : ST_FULL;
            state  <= S_IDLE;
          end else begin
            state <= (cnt == '0) ? S_P2_END : S_P2_RD;
          end
        end
        // pass two: copy kept entries into the other bank, placing the point
        S_P2_RD: state <= S_P2_EV;
        S_P2_EV: begin
          if (!e_rem) begin
            widx <= widx + CW'(1);
          end
          if (!e_rem && !placed && cur.x > pt.x) begin
            placed <= 1'b1;
            state  <= S_P2_EV2;
          end else if (last_idx) begin
            state <= S_P2_END;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_P2_RD;
          end
        end
        S_P2_EV2: begin
          widx <= widx + CW'(1);
          if (last_idx) begin
            state <= S_P2_END;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_P2_RD;
          end
        end
        S_P2_END: begin
          cnt      <= placed ? widx : widx + CW'(1);
          count    <= 7'(placed ? widx : widx + CW'(1));
          bank     <= ~bank;
          accepted <= 1'b1;
          status   <= ST_OK;
          state    <= S_IDLE;
        end
        S_AR_RD: state <= S_AR_EV;
        S_AR_EV: begin
          px <= cur.x;
          py <= cur.y;
          if (last_idx) begin
            state <= S_AR_FIN;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_AR_RD;
          end
        end
        S_AR_FIN: state <= S_AR_W1;
        S_AR_W1:  state <= S_AR_W2;
        S_AR_W2: begin
          area   <= acc;
          count  <= 7'(cnt);
          status <= ST_OK;
          state  <= S_IDLE;
        end
        S_RL_RD: state <= S_RL_EV;
        S_RL_EV: begin
          last_x    <= cur.x;
          last_y    <= cur.y;
          last_pred <= cur.pred;
          last_tag  <= cur.tag;
          count     <= 7'(cnt);
          status    <= ST_OK;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_acc_ok: assert property (@(posedge clk) disable iff (rst)
      (done && accepted) |-> (status == ST_OK))
    else $error("stored point with failing status");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && (opcode == OP_INSERT)) |=> busy)
    else $error("insert transaction did not start");

endmodule

### tb/pareto_front_2d_insert_top_test.sv
// Testbench for pareto_front_2d_insert_top: directed table, then random commands
// checked against a behavioral model of the nondominated set. Depends on pf2d_pkg.
module pareto_front_2d_insert_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pf2d_pkg::*;

  localparam int CAP = 64;
  localparam int N_RANDOM = 970;

  typedef struct {
    logic [1:0]  op;
    logic [30:0] x, y;
    logic [15:0] pred, tag;
    logic [30:0] lx, by, ty, rx;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic [6:0]  count;
    logic signed [63:0] area;
    logic [30:0] last_x, last_y;
    logic [15:0] last_pred, last_tag;
  } resp_t;

  typedef struct {
    cmd_t  c;
    bit    fixed;
    resp_t r;
  } row_t;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done;
  logic [1:0] opcode = '0;
  logic [30:0] x = '0, y = '0, left_x = '0, bottom_y = '0, top_y = '0, right_x = '0;
  logic [15:0] pred = '0, tag = '0;
  logic accepted;
  logic [1:0] status;
  logic [6:0] count;
  logic signed [63:0] area;
  logic [30:0] last_x, last_y;
  logic [15:0] last_pred, last_tag;

  pareto_front_2d_insert_top #(.CAPACITY(CAP)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  entry_t front[$];
  resp_t  pending_resp[$];
  row_t   rows[$];
  int     errors = 0;

  function automatic void add_row(cmd_t c, bit fixed, resp_t r);
    row_t w;
    w.c = c;
    w.fixed = fixed;
    w.r = r;
    rows = {rows, w};
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  function automatic longint sdiff(logic [30:0] a, logic [30:0] b);
    return longint'({33'd0, a}) - longint'({33'd0, b});
  endfunction

  function automatic resp_t apply_cmd(cmd_t c);
    resp_t r;
    entry_t e, kept[$];
    int removed;
    bit placed;
    longint acc;
    r = '{default: '0};
    e = '{x: c.x, y: c.y, pred: c.pred, tag: c.tag};
    case (c.op)
      OP_INSERT: begin
        removed = 0;
        r.status = ST_OK;
        foreach (front[i]) begin
          if (front[i].x <= c.x && front[i].y <= c.y) r.status = ST_DOMINATED;
          else if (front[i].x >= c.x && front[i].y >= c.y) removed++;
        end
        if (r.status == ST_OK && removed == 0 && front.size() >= CAP) r.status = ST_FULL;
        if (r.status == ST_OK) begin
          placed = 0;
          foreach (front[i]) begin
            if (front[i].x >= c.x && front[i].y >= c.y) continue;
            if (!placed && front[i].x > c.x) begin
              kept = {kept, e};
              placed = 1;
            end
            kept = {kept, front[i]};
          end
          if (!placed) kept = {kept, e};
          front = kept;
          r.accepted = 1;
        end
      end
      OP_APPEND: begin
        if (front.size() >= CAP) r.status = ST_FULL;
        else begin
          front = {front, e};
          r.accepted = 1;
        end
      end
      default: begin
        if (front.size() == 0) r.status = ST_EMPTY;
        else if (c.op == OP_AREA) begin
          acc = sdiff(front[0].x, c.lx) * sdiff(c.ty, c.by);
          for (int i = 1; i < front.size(); i++)
            acc = sat_sum(acc, sdiff(front[i].x, front[i-1].x) * sdiff(front[i-1].y, c.by));
          r.area = sat_sum(acc, sdiff(c.rx, front[$].x) * sdiff(front[$].y, c.by));
        end else begin
          r.last_x = front[$].x;
          r.last_y = front[$].y;
          r.last_pred = front[$].pred;
          r.last_tag = front[$].tag;
        end
      end
    endcase
    r.count = 7'(front.size());
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(cmd_t c, bit fixed, resp_t fr);
    resp_t r;
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    opcode <= c.op; x <= c.x; y <= c.y; pred <= c.pred; tag <= c.tag;
    left_x <= c.lx; bottom_y <= c.by; top_y <= c.ty; right_x <= c.rx;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_cmd(c);
    if (fixed && r != fr) begin
      $error("table row disagrees with model for opcode %0d", c.op);
      errors++;
    end
    pending_resp = {pending_resp, r};
    @(negedge clk);
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    resp_t e;
    if (!rst && done) begin
      if (pending_resp.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        e = pending_resp.pop_front();
        if (accepted !== e.accepted) begin
          $error("accepted exp %0h got %0h", e.accepted, accepted); errors++; end
        if (status !== e.status) begin
          $error("status exp %0h got %0h", e.status, status); errors++; end
        if (count !== e.count) begin
          $error("count exp %0d got %0d", e.count, count); errors++; end
        if (area !== e.area) begin
          $error("area exp %0d got %0d", e.area, area); errors++; end
        if (last_x !== e.last_x) begin
          $error("last_x exp %0h got %0h", e.last_x, last_x); errors++; end
        if (last_y !== e.last_y) begin
          $error("last_y exp %0h got %0h", e.last_y, last_y); errors++; end
        if (last_pred !== e.last_pred) begin
          $error("last_pred exp %0h got %0h", e.last_pred, last_pred); errors++; end
        if (last_tag !== e.last_tag) begin
          $error("last_tag exp %0h got %0h", e.last_tag, last_tag); errors++; end
      end
    end
  end

  function automatic cmd_t mk(logic [1:0] op, logic [30:0] px, logic [30:0] py,
                              logic [15:0] pp, logic [15:0] pt);
    cmd_t c;
    c = '{op: op, x: px, y: py, pred: pp, tag: pt, lx: 0, by: 0, ty: 0, rx: 0};
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int mode);
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.op = r < 55 ? OP_INSERT : r < 65 ? OP_APPEND : r < 85 ? OP_AREA : OP_READ_LAST;
    // narrow coordinates give plenty of dominance and removals
    if (mode == 0) begin
      c.x = 31'($urandom_range(0, 200));
      c.y = 31'($urandom_range(0, 200));
    end else begin
      c.x = 31'($urandom());
      c.y = 31'($urandom());
    end
    c.pred = 16'($urandom()); c.tag = 16'($urandom());
    c.lx = 31'($urandom()); c.by = 31'($urandom());
    c.ty = 31'($urandom()); c.rx = 31'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      c.lx = 31'($urandom_range(0, 100)); c.by = 31'($urandom_range(0, 100));
      c.ty = 31'($urandom_range(100, 400)); c.rx = 31'($urandom_range(100, 400));
    end
    return c;
  endfunction

  initial begin
    resp_t z;
    cmd_t c;
    int mode;
    z = '{default: '0};
    // empty-set queries, then extremes
    z.status = ST_EMPTY;
    add_row(mk(OP_READ_LAST, 0, 0, 0, 0), 1, z);
    add_row(mk(OP_AREA, 0, 0, 0, 0), 1, z);
    z = '{default: '0}; z.accepted = 1; z.count = 1;
    add_row(mk(OP_INSERT, 31'h7FFF_FFFF, 0, 16'hFFFF, 16'hFFFF), 1, z);
    z.accepted = 0; z.status = ST_DOMINATED;
    add_row(mk(OP_INSERT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0), 1, z);
    z.last_x = 31'h7FFF_FFFF; z.status = ST_OK; z.last_pred = 16'hFFFF;
    z.last_tag = 16'hFFFF;
    add_row(mk(OP_READ_LAST, 0, 0, 0, 0), 1, z);
    add_row(mk(OP_INSERT, 0, 31'h7FFF_FFFF, 1, 2), 0, z);
    add_row(mk(OP_INSERT, 100, 100, 3, 4), 0, z);
    add_row(mk(OP_INSERT, 100, 100, 5, 6), 0, z);
    add_row(mk(OP_INSERT, 50, 50, 7, 8), 0, z);
    c = mk(OP_AREA, 0, 0, 0, 0);
    c.ty = 31'h7FFF_FFFF; c.rx = 31'h7FFF_FFFF;
    add_row(c, 0, z);
    c.lx = 31'h7FFF_FFFF; c.by = 31'h7FFF_FFFF; c.ty = 0; c.rx = 0;
    add_row(c, 0, z);
    add_row(mk(OP_APPEND, 10, 10, 9, 9), 0, z);
    add_row(mk(OP_APPEND, 5, 5000, 9, 9), 0, z);
    add_row(mk(OP_INSERT, 7, 20, 11, 12), 0, z);
    add_row(mk(OP_INSERT, 1, 1, 13, 14), 0, z);
    add_row(mk(OP_READ_LAST, 0, 0, 0, 0), 0, z);
    // fill to capacity by appends, then hit the full cases
    for (int i = 0; i < CAP; i++)
      add_row(mk(OP_APPEND, 31'(32'h4000_0000 + i), 31'(32'h4000_0000 - i),
                 16'(i), 16'(i)), 0, z);
    add_row(mk(OP_INSERT, 31'h7FFF_0000, 0, 1, 1), 0, z);
    add_row(mk(OP_INSERT, 0, 0, 1, 1), 0, z);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[i]) issue(rows[i].c, rows[i].fixed, rows[i].r);
    mode = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) mode = $urandom_range(0, 1);
      issue(rand_cmd(mode), 0, z);
    end
    start <= 0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("pareto_front_2d_insert_top_test passed");
    else $display("pareto_front_2d_insert_top_test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("pareto_front_2d_insert_top_test failed");
    $finish;
  end
endmodule

### sim.f
design/pf2d_pkg.sv
design/pf2d_mem.sv
design/pf2d_area.sv
design/pareto_front_2d_insert_top.sv
tb/pareto_front_2d_insert_top_test.sv
